[hdl/replay_packet_deframer_unit_defines.svh]
// Assertion macros shared by the deframer modules.
`ifndef REPLAY_PACKET_DEFRAMER_UNIT_DEFINES_SVH
`define REPLAY_PACKET_DEFRAMER_UNIT_DEFINES_SVH

// Clocked property, masked while in reset.
`define RPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never hold outside reset.
`define RPD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

[hdl/rpd_pkg.sv]
// Shared types and constants of the replay packet deframer.
package rpd_pkg;

  localparam int unsigned QDEPTH = 4;

  typedef enum logic [1:0] {
    KIND_HDR  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  localparam logic [31:0] MASK_2B  = 32'h0000_4000;
  localparam logic [31:0] MASK_3B  = 32'h0020_0000;
  localparam logic [31:0] MASK_4B  = 32'h1000_0000;
  localparam logic [7:0]  TS_FLAG  = 8'h10;
  localparam logic [7:0]  TYPE_IDS = 8'h04;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  ptype;
    logic [31:0] ts;
    logic        has_ids;
    logic [31:0] ids;
    logic [31:0] len;
    logic [7:0]  value;
    logic        pend;
    logic        trunc;
  } rpd_rec_t;

endpackage

[hdl/rpd_front.sv]
// Front end: byte parser that classifies each beat and builds result records.
`include "replay_packet_deframer_unit_defines.svh"

module rpd_front import rpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       beat_i,
  input  logic [7:0] data_i,
  input  logic       eos_i,
  output logic       push_o,
  output rpd_rec_t   rec_o
);

  typedef enum logic [5:0] {
    PH_PREFIX0 = 6'b000001,
    PH_MORE    = 6'b000010,
    PH_TYPE    = 6'b000100,
    PH_TS      = 6'b001000,
    PH_IDS     = 6'b010000,
    PH_PAYLOAD = 6'b100000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        halted_q, halted_d;
  logic [31:0] last_ts_q, last_ts_d;
  logic [2:0]  need_q, need_d;
  logic        le_q, le_d;
  logic [1:0]  sshift_q, sshift_d;
  logic [1:0]  tcnt_q, tcnt_d;
  logic [1:0]  idcnt_q, idcnt_d;
  logic        has_ids_q, has_ids_d;
  logic [31:0] psize_q, psize_d;
  logic [31:0] left_q, left_d;
  logic [31:0] mask_q, mask_d;
  logic [31:0] ts_acc_q, ts_acc_d;
  logic [7:0]  type_q, type_d;
  logic [31:0] id_acc_q, id_acc_d;
  logic [31:0] cur_ts_q, cur_ts_d;

  logic [31:0] left_dec;
  logic        left_last;
  logic [31:0] psize_more, psize_fin;
  logic [31:0] ts_new, id_new;
  logic        hd, err, push;
  logic [31:0] hd_ts;
  logic [7:0]  hd_type;
  rpd_rec_t    rec;

  assign left_dec   = left_q - 32'd1;
  assign left_last  = (left_q == 32'd1);
  assign psize_more = le_q ? (psize_q | ({24'd0, data_i} << {sshift_q, 3'b000}))
                           : {psize_q[23:0], data_i};
  assign psize_fin  = le_q ? psize_more : (psize_more ^ mask_q);
  assign ts_new     = ts_acc_q | ({24'd0, data_i} << {tcnt_q, 3'b000});
  assign id_new     = id_acc_q | ({24'd0, data_i} << {idcnt_q, 3'b000});

  always_comb begin
    phase_d   = phase_q;
    halted_d  = halted_q;
    last_ts_d = last_ts_q;
    need_d    = need_q;
    le_d      = le_q;
    sshift_d  = sshift_q;
    tcnt_d    = tcnt_q;
    idcnt_d   = idcnt_q;
    has_ids_d = has_ids_q;
    psize_d   = psize_q;
    left_d    = left_q;
    mask_d    = mask_q;
    ts_acc_d  = ts_acc_q;
    type_d    = type_q;
    id_acc_d  = id_acc_q;
    cur_ts_d  = cur_ts_q;
    push      = 1'b0;
    rec       = '0;
    hd        = 1'b0;
    err       = 1'b0;
    hd_ts     = last_ts_q;
    hd_type   = type_q;
    if (beat_i && !halted_q) begin
      unique case (phase_q)
        PH_PREFIX0: begin
          sshift_d = 2'd0;
          le_d     = 1'b0;
          if (data_i[7]) begin
            if (data_i[6]) begin
              err      = 1'b1;
              halted_d = 1'b1;
              push     = 1'b1;
              rec.kind = KIND_ERR;
              rec.pend = 1'b1;
            end else begin
              psize_d = {25'd0, data_i[6:0]};
              left_d  = {25'd0, data_i[6:0]};
              phase_d = (data_i[6:0] == 7'd0) ? PH_PREFIX0 : PH_TYPE;
            end
          end else begin
            psize_d = {24'd0, data_i};
            phase_d = PH_MORE;
            if (data_i[6]) begin
              need_d = 3'd1;
              mask_d = MASK_2B;
            end else if (data_i[5]) begin
              need_d = 3'd2;
              mask_d = MASK_3B;
            end else if (data_i[4]) begin
              need_d = 3'd3;
              mask_d = MASK_4B;
            end else begin
              need_d  = 3'd4;
              le_d    = 1'b1;
              psize_d = '0;
            end
          end
        end
        PH_MORE: begin
          sshift_d = sshift_q + 2'd1;
          psize_d  = psize_more;
          need_d   = need_q - 3'd1;
          if (need_q == 3'd1) begin
            psize_d = psize_fin;
            left_d  = psize_fin;
            phase_d = (psize_fin == 32'd0) ? PH_PREFIX0 : PH_TYPE;
          end
        end
        PH_TYPE: begin
          left_d    = left_dec;
          has_ids_d = 1'b0;
          if (data_i[4]) begin
            hd_type = data_i ^ TS_FLAG;
            type_d  = data_i ^ TS_FLAG;
            hd      = 1'b1;
          end else begin
            hd_type  = data_i;
            type_d   = data_i;
            ts_acc_d = '0;
            tcnt_d   = 2'd0;
            if (left_last) begin
              hd = 1'b1;
            end else begin
              phase_d = PH_TS;
            end
          end
        end
        PH_TS: begin
          left_d   = left_dec;
          ts_acc_d = ts_new;
          tcnt_d   = tcnt_q + 2'd1;
          if (tcnt_q == 2'd3) begin
            hd    = 1'b1;
            hd_ts = ts_new;
          end else if (left_last) begin
            hd = 1'b1;
          end
        end
        PH_IDS: begin
          left_d   = left_dec;
          id_acc_d = id_new;
          idcnt_d  = idcnt_q + 2'd1;
          if (idcnt_q == 2'd3) begin
            has_ids_d   = 1'b1;
            push        = 1'b1;
            rec.kind    = KIND_HDR;
            rec.ptype   = type_q;
            rec.ts      = cur_ts_q;
            rec.has_ids = 1'b1;
            rec.ids     = id_new;
            rec.len     = psize_q;
            rec.pend    = left_last;
            phase_d     = left_last ? PH_PREFIX0 : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          left_d      = left_dec;
          push        = 1'b1;
          rec.kind    = KIND_DATA;
          rec.ptype   = type_q;
          rec.ts      = cur_ts_q;
          rec.has_ids = has_ids_q;
          rec.ids     = has_ids_q ? id_acc_q : 32'd0;
          rec.len     = psize_q;
          rec.value   = data_i;
          rec.pend    = left_last;
          if (left_last) begin
            phase_d = PH_PREFIX0;
          end
        end
        default: begin
          phase_d = PH_PREFIX0;
        end
      endcase

      if (hd) begin
        cur_ts_d  = hd_ts;
        last_ts_d = hd_ts;
        if (hd_type == TYPE_IDS && left_dec >= 32'd4) begin
          id_acc_d = '0;
          idcnt_d  = 2'd0;
          phase_d  = PH_IDS;
        end else begin
          push      = 1'b1;
          rec.kind  = KIND_HDR;
          rec.ptype = hd_type;
          rec.ts    = hd_ts;
          rec.len   = psize_q;
          rec.pend  = left_last;
          phase_d   = left_last ? PH_PREFIX0 : PH_PAYLOAD;
        end
      end

      if (eos_i && !err) begin
        if (push) begin
          if (phase_d != PH_PREFIX0) begin
            rec.pend  = 1'b1;
            rec.trunc = 1'b1;
          end
        end else if (phase_d == PH_MORE) begin
          push      = 1'b1;
          rec       = '0;
          rec.kind  = KIND_ERR;
          rec.pend  = 1'b1;
          rec.trunc = 1'b1;
          halted_d  = 1'b1;
        end else if (phase_d == PH_TS || phase_d == PH_IDS) begin
          push      = 1'b1;
          rec       = '0;
          rec.kind  = KIND_HDR;
          rec.ptype = type_d;
          rec.ts    = (phase_d == PH_TS) ? last_ts_d : cur_ts_d;
          rec.len   = psize_d;
          rec.pend  = 1'b1;
          rec.trunc = 1'b1;
        end
        phase_d   = PH_PREFIX0;
        last_ts_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_PREFIX0;
      halted_q  <= 1'b0;
      last_ts_q <= '0;
      need_q    <= '0;
      le_q      <= 1'b0;
      sshift_q  <= '0;
      tcnt_q    <= '0;
      idcnt_q   <= '0;
      has_ids_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      halted_q  <= halted_d;
      last_ts_q <= last_ts_d;
      need_q    <= need_d;
      le_q      <= le_d;
      sshift_q  <= sshift_d;
      tcnt_q    <= tcnt_d;
      idcnt_q   <= idcnt_d;
      has_ids_q <= has_ids_d;
    end
  end

  always_ff @(posedge clk_i) begin
    psize_q  <= psize_d;
    left_q   <= left_d;
    mask_q   <= mask_d;
    ts_acc_q <= ts_acc_d;
    type_q   <= type_d;
    id_acc_q <= id_acc_d;
    cur_ts_q <= cur_ts_d;
  end

  assign push_o = push;
  assign rec_o  = rec;

  `RPD_ASSERT(a_halt_sticky, halted_q |=> halted_q, "halt cleared without reset")
  `RPD_NEVER(a_halt_silent, halted_q && push, "record pushed while halted")

endmodule

[hdl/rpd_queue.sv]
// Short record queue between the parser and the output stage.
`include "replay_packet_deframer_unit_defines.svh"

module rpd_queue import rpd_pkg::*; #(
  parameter int unsigned Depth = QDEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  rpd_rec_t rec_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output rpd_rec_t rec_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  rpd_rec_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  `RPD_NEVER(a_no_overflow, push_i && full_o, "push into full queue")

endmodule

[hdl/rpd_back.sv]
// Back end: output register that formats queued records into result beats.
`include "replay_packet_deframer_unit_defines.svh"

module rpd_back import rpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  rpd_rec_t    rec_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  packet_type_o,
  output logic [31:0] timestamp_ms_o,
  output logic        has_ids_o,
  output logic [15:0] object_id_o,
  output logic [15:0] message_id_o,
  output logic [31:0] declared_length_o,
  output logic [7:0]  payload_value_o,
  output logic        packet_end_o,
  output logic        truncated_o
);

  logic        out_valid_q, out_valid_d;
  logic        pop;
  kind_e       kind_q;
  logic [7:0]  ptype_q;
  logic [31:0] ts_q;
  logic        has_ids_q;
  logic [15:0] obj_q, msg_q;
  logic [31:0] len_q;
  logic [7:0]  value_q;
  logic        pend_q, trunc_q;
  logic        is_err;

  assign pop         = valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_d = pop || (out_valid_q && !out_ready_i);
  assign is_err      = (rec_i.kind == KIND_ERR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      kind_q    <= rec_i.kind;
      ptype_q   <= is_err ? 8'd0 : rec_i.ptype;
      ts_q      <= is_err ? 32'd0 : rec_i.ts;
      has_ids_q <= rec_i.has_ids && !is_err;
      obj_q     <= (rec_i.has_ids && !is_err) ? rec_i.ids[15:0] : 16'd0;
      msg_q     <= (rec_i.has_ids && !is_err) ? rec_i.ids[31:16] : 16'd0;
      len_q     <= is_err ? 32'd0 : rec_i.len;
      value_q   <= (rec_i.kind == KIND_DATA) ? rec_i.value : 8'd0;
      pend_q    <= rec_i.pend;
      trunc_q   <= rec_i.trunc;
    end
  end

  assign pop_o             = pop;
  assign out_valid_o       = out_valid_q;
  assign kind_o            = kind_q;
  assign packet_type_o     = ptype_q;
  assign timestamp_ms_o    = ts_q;
  assign has_ids_o         = has_ids_q;
  assign object_id_o       = obj_q;
  assign message_id_o      = msg_q;
  assign declared_length_o = len_q;
  assign payload_value_o   = value_q;
  assign packet_end_o      = pend_q;
  assign truncated_o       = trunc_q;

  `RPD_ASSERT(a_err_closes, out_valid_q && kind_q == KIND_ERR |-> pend_q && !has_ids_q, "bad error beat")

endmodule

[hdl/replay_packet_deframer_unit.sv]
// Top level of the replay packet deframer: parser, record queue, output stage.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------
//  in      | input     | in_valid_i/in_ready_o  | data_byte_i, end_of_stream_i
//  out     | output    | out_valid_o/out_ready_i| kind_o .. truncated_o (ten fields)
//
// One beat per cycle while in_ready_o is high; each yields zero or one result beat.
// The parser updates its state in the cycle a beat is taken; in_ready_o drops only
// when the QDepth-entry record queue is full, so output stalls reach the input late.
// Reset is asynchronous and needs no clearing pass; the block is ready right after it.
// After a size prefix error, input beats are still taken and dropped until reset.
module replay_packet_deframer_unit import rpd_pkg::*; #(
  parameter int unsigned QDepth = QDEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  packet_type_o,
  output logic [31:0] timestamp_ms_o,
  output logic        has_ids_o,
  output logic [15:0] object_id_o,
  output logic [15:0] message_id_o,
  output logic [31:0] declared_length_o,
  output logic [7:0]  payload_value_o,
  output logic        packet_end_o,
  output logic        truncated_o
);

  logic     beat;
  logic     push;
  rpd_rec_t front_rec;
  logic     q_full, q_valid, q_pop;
  rpd_rec_t q_rec;

  assign in_ready_o = !q_full;
  assign beat       = in_valid_i && in_ready_o;

  rpd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (beat),
    .data_i (data_byte_i),
    .eos_i  (end_of_stream_i),
    .push_o (push),
    .rec_o  (front_rec)
  );

  rpd_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (front_rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rec_o   (q_rec)
  );

  rpd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (q_valid),
    .rec_i             (q_rec),
    .pop_o             (q_pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_o            (kind_o),
    .packet_type_o     (packet_type_o),
    .timestamp_ms_o    (timestamp_ms_o),
    .has_ids_o         (has_ids_o),
    .object_id_o       (object_id_o),
    .message_id_o      (message_id_o),
    .declared_length_o (declared_length_o),
    .payload_value_o   (payload_value_o),
    .packet_end_o      (packet_end_o),
    .truncated_o       (truncated_o)
  );

endmodule
